/* hw/rtl/jmsr_pkg.sv */
// ----------------------------------------------------------------------------
// jmsr_pkg: shared types and constants for the jog motor soft ramp
// Duty width, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package jmsr_pkg;

  localparam int unsigned DUTY_W = 8;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 2;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  localparam logic [DUTY_W-1:0] MIN_SPEED_RST = 8'd25;
  localparam logic [DUTY_W-1:0] STEP_UP_RST   = 8'd4;
  localparam logic [DUTY_W-1:0] STEP_DOWN_RST = 8'd10;

  localparam logic [IDX_W-1:0] REG_MIN_SPEED = 2'd0;
  localparam logic [IDX_W-1:0] REG_STEP_UP   = 2'd1;
  localparam logic [IDX_W-1:0] REG_STEP_DOWN = 2'd2;

  typedef struct packed {
    logic [DUTY_W-1:0] min_speed;
    logic [DUTY_W-1:0] step_up;
    logic [DUTY_W-1:0] step_down;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/jmsr_cfg.sv */
// ----------------------------------------------------------------------------
// jmsr_cfg: APB register file
// Holds min_speed, step_up and step_down; writes to unmapped offsets drop.
// ----------------------------------------------------------------------------
`default_nettype none

module jmsr_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [jmsr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [jmsr_pkg::DATA_W-1:0]  pwdata,
  output logic      [jmsr_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  output jmsr_pkg::cfg_t                    cfg_o
);

  jmsr_pkg::cfg_t               cfg_q;
  logic                         wr_en;
  logic [jmsr_pkg::IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[jmsr_pkg::ADDR_W-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_speed <= jmsr_pkg::MIN_SPEED_RST;
      cfg_q.step_up   <= jmsr_pkg::STEP_UP_RST;
      cfg_q.step_down <= jmsr_pkg::STEP_DOWN_RST;
    end else if (wr_en) begin
      case (idx)
        jmsr_pkg::REG_MIN_SPEED: cfg_q.min_speed <= pwdata[jmsr_pkg::DUTY_W-1:0];
        jmsr_pkg::REG_STEP_UP:   cfg_q.step_up   <= pwdata[jmsr_pkg::DUTY_W-1:0];
        jmsr_pkg::REG_STEP_DOWN: cfg_q.step_down <= pwdata[jmsr_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      jmsr_pkg::REG_MIN_SPEED: prdata[jmsr_pkg::DUTY_W-1:0] = cfg_q.min_speed;
      jmsr_pkg::REG_STEP_UP:   prdata[jmsr_pkg::DUTY_W-1:0] = cfg_q.step_up;
      jmsr_pkg::REG_STEP_DOWN: prdata[jmsr_pkg::DUTY_W-1:0] = cfg_q.step_down;
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/jmsr_ramp.sv */
// ----------------------------------------------------------------------------
// jmsr_ramp: one direction duty ramp
// Driven: rise by step_up (from min_speed when idle), clamp to ceiling.
// Released: fall by step_down, saturate at zero, snap below min_speed.
// ----------------------------------------------------------------------------
`default_nettype none

module jmsr_ramp (
  input  wire logic [jmsr_pkg::DUTY_W-1:0]  duty_i,
  input  wire logic                         drive_i,
  input  wire logic [jmsr_pkg::DUTY_W-1:0]  ceiling_i,
  input  wire jmsr_pkg::cfg_t               cfg_i,
  output logic      [jmsr_pkg::DUTY_W-1:0]  duty_o
);

  logic [jmsr_pkg::DUTY_W-1:0] base;
  logic [jmsr_pkg::DUTY_W:0]   sum;
  logic [jmsr_pkg::DUTY_W-1:0] rise_sat;
  logic [jmsr_pkg::DUTY_W-1:0] rise;
  logic [jmsr_pkg::DUTY_W-1:0] fall;

  always_comb begin
    base     = (duty_i == '0) ? cfg_i.min_speed : duty_i;
    sum      = {1'b0, base} + {1'b0, cfg_i.step_up};
    rise_sat = (sum > {1'b0, jmsr_pkg::DUTY_MAX}) ? jmsr_pkg::DUTY_MAX
                                                  : sum[jmsr_pkg::DUTY_W-1:0];
    rise     = (rise_sat > ceiling_i) ? ceiling_i : rise_sat;
    fall     = (duty_i <= cfg_i.step_down) ? '0 : duty_i - cfg_i.step_down;
    if (fall < cfg_i.min_speed) begin
      fall = '0;
    end
    duty_o   = drive_i ? rise : fall;
  end

endmodule

`default_nettype wire

/* hw/rtl/jog_motor_soft_ramp.sv */
// ----------------------------------------------------------------------------
// jog_motor_soft_ramp: soft-start slew-rate limiter for one jog motor axis
// Result: registered, valid in the cycle after the input transfer.
// Throughput: one tick per cycle; input ready while the result slot is empty
//   or being drained in the same cycle.
// Reset: duties clear to zero, ceiling to full scale, registers to defaults,
//   no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module jog_motor_soft_ramp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         forward_pressed_i,
  input  wire logic                         reverse_pressed_i,
  input  wire logic [jmsr_pkg::DUTY_W-1:0]  speed_limit_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [jmsr_pkg::DUTY_W-1:0]  forward_duty_o,
  output logic      [jmsr_pkg::DUTY_W-1:0]  reverse_duty_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [jmsr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [jmsr_pkg::DATA_W-1:0]  pwdata,
  output logic      [jmsr_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);

  jmsr_pkg::cfg_t               cfg;
  logic                         in_xfer;
  logic                         out_valid_q;
  logic [jmsr_pkg::DUTY_W-1:0]  fwd_q, fwd_d;
  logic [jmsr_pkg::DUTY_W-1:0]  rev_q, rev_d;
  logic [jmsr_pkg::DUTY_W-1:0]  ceil_q, ceil_d;
  logic [jmsr_pkg::DUTY_W-1:0]  ceil_gap;

  jmsr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_xfer    = in_valid_i & in_ready_o;

  // ceiling steps down toward a lower limit, jumps to a higher one
  always_comb begin
    ceil_gap = ceil_q - speed_limit_i;
    if (speed_limit_i < ceil_q) begin
      ceil_d = (ceil_gap <= cfg.step_down) ? speed_limit_i : ceil_q - cfg.step_down;
    end else begin
      ceil_d = speed_limit_i;
    end
  end

  jmsr_ramp u_fwd (
    .duty_i    (fwd_q),
    .drive_i   (forward_pressed_i & (rev_q == '0)),
    .ceiling_i (ceil_d),
    .cfg_i     (cfg),
    .duty_o    (fwd_d)
  );

  // reverse sees the new forward duty
  jmsr_ramp u_rev (
    .duty_i    (rev_q),
    .drive_i   (reverse_pressed_i & (fwd_d == '0)),
    .ceiling_i (ceil_d),
    .cfg_i     (cfg),
    .duty_o    (rev_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fwd_q       <= '0;
      rev_q       <= '0;
      ceil_q      <= jmsr_pkg::DUTY_MAX;
    end else begin
      if (in_xfer) begin
        out_valid_q <= 1'b1;
        fwd_q       <= fwd_d;
        rev_q       <= rev_d;
        ceil_q      <= ceil_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign forward_duty_o = fwd_q;
  assign reverse_duty_o = rev_q;

endmodule

`default_nettype wire

/* hw/rtl/jmsr_checker.sv */
// ----------------------------------------------------------------------------
// jmsr_checker: port-level checks for jog_motor_soft_ramp
// Result handshake, tick-to-result timing, drive exclusivity and ready when the result slot is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module jmsr_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic                         in_ready_o,
  input  wire logic                         out_valid_o,
  input  wire logic                         out_ready_i,
  input  wire logic [jmsr_pkg::DUTY_W-1:0]  forward_duty_o,
  input  wire logic [jmsr_pkg::DUTY_W-1:0]  reverse_duty_o,
  input  wire logic                         pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o
      && $stable(forward_duty_o) && $stable(reverse_duty_o))
    else $error("result changed while stalled");

  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("transfer without result");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> forward_duty_o == '0 || reverse_duty_o == '0)
    else $error("both directions driven");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o && pready)
    else $error("stalled with empty result slot");

endmodule

bind jog_motor_soft_ramp jmsr_checker u_jmsr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .forward_duty_o (forward_duty_o),
  .reverse_duty_o (reverse_duty_o),
  .pready         (pready)
);

`default_nettype wire
